// ----- sv/sra_pkg.sv -----
// ----------------------------------------------------------------------------
// sra_pkg: shared types and constants of the segment reassembler
// Status codes, the bank geometry of the message store and the records
// that pass between the top level and the store lanes.
// ----------------------------------------------------------------------------
`default_nettype none

package sra_pkg;

  // Widths fixed by the frame and result formats
  localparam int BYTE_W     = 8;
  localparam int CTR_W      = 8;
  localparam int IDX_W      = 7;
  localparam int LEN_W      = 7;
  localparam int STAT_W     = 3;
  localparam int PAY_FIELDS = 6;

  // The store is split into eight byte-wide banks, interleaved on the low
  // address bits, so that up to eight consecutive bytes land in one cycle.
  localparam int NUM_BANKS  = 8;
  localparam int BANK_W     = 3;
  localparam int CNT_W      = 4;
  localparam int MAX_ADDR_W = 8;

  typedef enum logic [STAT_W-1:0] {
    ST_PARTIAL  = 3'd0,
    ST_COMPLETE = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_OVERFLOW = 3'd3,
    ST_READ     = 3'd4
  } status_e;

  typedef logic [NUM_BANKS-1:0][BYTE_W-1:0] byte_vec_t;

  // Write request broadcast to every bank lane
  typedef struct packed {
    logic                  en;
    logic [CNT_W-1:0]      count;
    logic [MAX_ADDR_W-1:0] base;
  } wr_req_t;

  // Result record waiting for the bank read data
  typedef struct packed {
    status_e           status;
    logic [LEN_W-1:0]  length;
    logic              msg_ready;
    logic              is_read;
    logic [BANK_W-1:0] bank;
  } s1_t;

endpackage

`default_nettype wire

// ----- sv/sra_if.sv -----
// ----------------------------------------------------------------------------
// sra_if: request and result channels of the segment reassembler
// Valid/ready channels; a request moves when valid and ready are both high.
// ----------------------------------------------------------------------------
`default_nettype none

interface sra_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] start_ctr;
  logic [7:0] end_ctr;
  logic [7:0] payload_0;
  logic [7:0] payload_1;
  logic [7:0] payload_2;
  logic [7:0] payload_3;
  logic [7:0] payload_4;
  logic [7:0] payload_5;
  logic [6:0] read_index;

  modport source (
    output valid, mode, start_ctr, end_ctr, payload_0, payload_1,
           payload_2, payload_3, payload_4, payload_5, read_index,
    input  ready
  );
  modport sink (
    input  valid, mode, start_ctr, end_ctr, payload_0, payload_1,
           payload_2, payload_3, payload_4, payload_5, read_index,
    output ready
  );
endinterface

interface sra_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [6:0] message_length;
  logic [7:0] read_data;
  logic       message_ready;

  modport source (
    output valid, status, message_length, read_data, message_ready,
    input  ready
  );
  modport sink (
    input  valid, status, message_length, read_data, message_ready,
    output ready
  );
endinterface

`default_nettype wire

// ----- sv/sra_ram.sv -----
// ----------------------------------------------------------------------------
// sra_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module sra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- sv/sra_lane.sv -----
// ----------------------------------------------------------------------------
// sra_lane: one bank of the message store
// Picks out the payload byte that falls into this bank for the current
// write request, and serves the bank's share of a read request.
// ----------------------------------------------------------------------------
`default_nettype none

module sra_lane
  import sra_pkg::*;
#(
  parameter int ADDR_W = 7,
  parameter int BANK   = 0
) (
  input  wire logic              clk_i,
  input  wire wr_req_t           wr_req_i,
  input  wire byte_vec_t         payload_i,
  input  wire logic              rd_en_i,
  input  wire logic [ADDR_W-1:0] rd_addr_i,
  output      logic [BYTE_W-1:0] rd_data_o
);

  localparam int ROW_W = ADDR_W - BANK_W;

  logic [BANK_W-1:0] offset;
  logic [ADDR_W-1:0] base;
  logic [ADDR_W-1:0] waddr;
  logic              we;

  // Byte number within the frame that maps onto this bank
  assign base   = wr_req_i.base[ADDR_W-1:0];
  assign offset = BANK_W'(BANK) - base[BANK_W-1:0];
  assign we     = wr_req_i.en && ({1'b0, offset} < wr_req_i.count);
  assign waddr  = base + ADDR_W'(offset);

  sra_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (1 << ROW_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr[ADDR_W-1:BANK_W]),
    .wdata_i (payload_i[offset]),
    .re_i    (rd_en_i),
    .raddr_i (rd_addr_i[ADDR_W-1:BANK_W]),
    .rdata_o (rd_data_o)
  );

endmodule

`default_nettype wire

// ----- sv/segment_reassembler_unit.sv -----
// ----------------------------------------------------------------------------
// segment_reassembler_unit: rebuilds messages from segmented frames
// An accepted request goes through stage 1 (s1_q) and out_q onto out_o.
// Throughput: one request per cycle while out_o is not stalled; the eight
// store banks take all payload bytes of a frame in the same cycle.
// Reset clears the fill count, the ready flag, the completed length and
// the pipeline; the message store itself is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module segment_reassembler_unit
  import sra_pkg::*;
#(
  parameter int MAX_FILL      = 120,
  // Power of two, 16 to 256
  parameter int STORE_DEPTH   = 128,
  parameter int PAYLOAD_BYTES = 6
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  sra_in_if.sink    in_i,
  sra_out_if.source out_o
);

  localparam int AW  = $clog2(STORE_DEPTH);
  localparam int PBE = (PAYLOAD_BYTES < PAY_FIELDS) ? PAYLOAD_BYTES : PAY_FIELDS;
  localparam int FW  = $clog2(MAX_FILL + PBE + 1);

  // Handshake
  logic in_acc, out_free, s1_adv;

  // Message state
  logic [FW-1:0]    fill_q, fill_d;
  logic             ready_q, ready_d;
  logic [LEN_W-1:0] clen_q, clen_d;

  // Frame decode
  logic [CTR_W-1:0] span;
  logic [CNT_W-1:0] n;
  logic [FW-1:0]    fill_sum;
  status_e          status;

  // Pipeline
  logic      s1_valid_q, s1_valid_d;
  s1_t       s1_q, s1_d;
  logic      out_valid_q, out_valid_d;
  s1_t       out_q;
  logic [BYTE_W-1:0] out_data_q;

  // Store lanes
  wr_req_t   wr_req;
  byte_vec_t payload;
  logic [AW-1:0] rd_addr;
  logic [NUM_BANKS-1:0][BYTE_W-1:0] bank_rdata;

  assign out_free  = !out_valid_q || out_o.ready;
  assign s1_adv    = s1_valid_q && out_free;
  assign in_i.ready = !s1_valid_q || out_free;
  assign in_acc    = in_i.valid && in_i.ready;

  // Segment span and bytes copied from this frame
  always_comb begin
    span     = in_i.end_ctr - in_i.start_ctr;
    n        = (span < CTR_W'(PBE)) ? CNT_W'(span) : CNT_W'(PBE);
    fill_sum = fill_q + FW'(n);
  end

  // Message state update
  always_comb begin
    fill_d  = fill_q;
    ready_d = ready_q;
    clen_d  = clen_q;
    status  = ST_READ;
    if (!in_i.mode) begin
      if (span == CTR_W'(n)) begin
        fill_d = '0;
        if (span == '0) begin
          ready_d = 1'b0;
          status  = ST_EMPTY;
        end else begin
          ready_d = 1'b1;
          clen_d  = LEN_W'(fill_sum);
          status  = ST_COMPLETE;
        end
      end else begin
        ready_d = 1'b0;
        if (fill_sum >= FW'(MAX_FILL)) begin
          fill_d = '0;
          status = ST_OVERFLOW;
        end else begin
          fill_d = fill_sum;
          status = ST_PARTIAL;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q  <= '0;
      ready_q <= 1'b0;
      clen_q  <= '0;
    end else if (in_acc) begin
      fill_q  <= fill_d;
      ready_q <= ready_d;
      clen_q  <= clen_d;
    end
  end

  // Write and read requests for the bank lanes
  assign payload[0] = in_i.payload_0;
  assign payload[1] = in_i.payload_1;
  assign payload[2] = in_i.payload_2;
  assign payload[3] = in_i.payload_3;
  assign payload[4] = in_i.payload_4;
  assign payload[5] = in_i.payload_5;
  assign payload[6] = '0;
  assign payload[7] = '0;

  assign wr_req.en    = in_acc && !in_i.mode;
  assign wr_req.count = n;
  assign wr_req.base  = MAX_ADDR_W'(AW'(fill_q));
  assign rd_addr      = AW'(in_i.read_index);

  for (genvar b = 0; b < NUM_BANKS; b++) begin : g_lane
    sra_lane #(
      .ADDR_W (AW),
      .BANK   (b)
    ) u_lane (
      .clk_i     (clk_i),
      .wr_req_i  (wr_req),
      .payload_i (payload),
      .rd_en_i   (in_acc && in_i.mode),
      .rd_addr_i (rd_addr),
      .rd_data_o (bank_rdata[b])
    );
  end

  // Stage 1: result record, bank reads in flight
  always_comb begin
    s1_d.status    = status;
    s1_d.length    = clen_d;
    s1_d.msg_ready = ready_d;
    s1_d.is_read   = in_i.mode;
    s1_d.bank      = rd_addr[BANK_W-1:0];
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_acc) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Merge: select the addressed bank and register the result
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q <= s1_d;
    end
    if (s1_adv) begin
      out_q      <= s1_q;
      out_data_q <= s1_q.is_read ? bank_rdata[s1_q.bank] : '0;
    end
  end

  assign out_o.valid          = out_valid_q;
  assign out_o.status         = out_q.status;
  assign out_o.message_length = out_q.length;
  assign out_o.read_data      = out_data_q;
  assign out_o.message_ready  = out_q.msg_ready;

  // Checks
  a_fill_below_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q < FW'(MAX_FILL))
    else $error("fill count reached the discard limit");

  a_accept_fills_s1: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> s1_valid_q)
    else $error("accepted request lost before stage 1");

  a_empty_segment: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !in_i.mode && (in_i.start_ctr == in_i.end_ctr))
      |=> (s1_q.status == ST_EMPTY) && (fill_q == '0))
    else $error("empty segment not reported or fill not cleared");

  a_data_only_on_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.status != ST_READ)) |-> (out_o.read_data == '0))
    else $error("read data driven on a frame result");

endmodule

`default_nettype wire
